// ----- hw/rtl/tfd_pkg.sv -----
package tfd_pkg;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int FW = FB + 1;
	localparam int NF = 6;

	localparam logic [1:0] KIND_MAX  = 2'd0;
	localparam logic [1:0] KIND_XAX  = 2'd1;
	localparam logic [1:0] KIND_YAX  = 2'd2;
	localparam logic [1:0] KIND_TURN = 2'd3;

	typedef struct packed {
		logic signed [DW-1:0] pos_x;
		logic signed [DW-1:0] pos_y;
		logic signed [DW-1:0] sample_time;
		logic signed [DW-1:0] distance;
		logic signed [DW-1:0] vel_x;
		logic signed [DW-1:0] vel_y;
		logic                 end_of_track;
	} sample_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic signed [DW-1:0] out_x;
		logic signed [DW-1:0] out_y;
		logic signed [DW-1:0] out_time;
		logic signed [DW-1:0] out_distance;
		logic signed [DW-1:0] out_vel_x;
		logic signed [DW-1:0] out_vel_y;
		logic                 last_result;
	} feature_t;

	typedef struct packed {
		logic          start;
		logic [DW:0]   num;
		logic [DW:0]   den;
	} div_req_t;

	function automatic logic crosses(logic signed [DW-1:0] p, logic signed [DW-1:0] c);
		crosses = (p <= 0 && c > 0) || (p > 0 && c <= 0);
	endfunction

endpackage

// ----- hw/rtl/tfd_sample_if.sv -----
interface tfd_sample_if import tfd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tfd_feature_if.sv -----
interface tfd_feature_if import tfd_pkg::*; ();
	logic     valid;
	logic     ready;
	feature_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/trajectory_feature_detector.sv -----
// channel   | dir | payload                                  | transaction
// samples   | in  | pos_x..vel_y, end_of_track               | valid & ready
// features  | out | kind, out_x..out_vel_y, last_result      | valid & ready
// cfg       | in  | cfg_wdata -> detect_extra                | cfg_we
// One sample at a time: ready only while idle. A crossing goes through the shared
// divider (17 steps, none when the fraction is one), then the shared multiplier, then
// emit, or it is held for a later sample.
// Reset clears all track state and detect_extra; features stall while
// the output register is full and not taken.
module trajectory_feature_detector import tfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tfd_sample_if.sink    samples,
	tfd_feature_if.source features,
	input  logic   cfg_we,
	input  logic   cfg_wdata
);
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECIDE = 7'b0000010,
		ST_PICK   = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_MUL    = 7'b0010000,
		ST_EMIT   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q;
	logic   extra_q;
	logic signed [DW-1:0] cur_q [NF];
	logic signed [DW-1:0] prev_q [NF];
	logic signed [DW-1:0] pt_q [NF];
	logic signed [DW-1:0] held_pt_q [2][NF];
	logic [1:0]  held_kind_q [2];
	logic [1:0]  held_cnt_q;
	logic        eot_q;
	logic signed [DW:0] pdir_q;
	logic signed [DW:0] ndir_q;
	logic        rising_q;
	logic        nrising_q;
	logic [1:0]  idx_q;
	logic [5:0]  ev_q;
	logic        hold_q;
	logic        cf_q;
	logic [1:0]  kind_q;
	logic [2:0]  mcnt_q;
	logic        ovalid_q;
	feature_t    out_q;

	logic signed [DW:0] dir;
	logic        turn, fall, rise, xc, yc;
	div_req_t    dreq;
	logic        ddone;
	logic [FW-1:0] frac;
	logic signed [DW-1:0] ma, mb, mres;
	logic signed [DW-1:0] cp, cc;
	logic [2:0]  fidx;

	assign dir  = {cur_q[3][DW-1], cur_q[3]} - {prev_q[3][DW-1], prev_q[3]};
	assign turn = (dir > 0 && pdir_q <= 0) || (dir < 0 && pdir_q >= 0);
	assign fall = cur_q[1] < prev_q[1];
	assign rise = cur_q[1] > prev_q[1];
	assign xc   = extra_q && crosses(prev_q[0], cur_q[0]);
	assign yc   = extra_q && crosses(prev_q[1], cur_q[1]);

	assign cp = ev_q[4] ? prev_q[0] : prev_q[1];
	assign cc = ev_q[4] ? cur_q[0] : cur_q[1];
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		if (state_q == ST_PICK && ev_q[3:0] == 4'b0000 && ev_q[5:4] != 2'b00) begin
			dreq.start = 1'b1;
		end
		if (cp <= 0) begin
			dreq.num = -{cp[DW-1], cp};
			dreq.den = {cc[DW-1], cc} - {cp[DW-1], cp};
		end else begin
			dreq.num = {cp[DW-1], cp};
			dreq.den = {cp[DW-1], cp} - {cc[DW-1], cc};
		end
	end

	tfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.frac   (frac)
	);

	assign fidx = (mcnt_q < 3'(NF)) ? mcnt_q : 3'd0;
	assign ma   = prev_q[fidx];
	assign mb   = cur_q[fidx];

	tfd_mul u_mul (
		.clk  (clk),
		.a    (ma),
		.b    (mb),
		.frac (frac),
		.res  (mres)
	);

	assign samples.ready  = state_q == ST_IDLE;
	assign features.valid = ovalid_q;
	assign features.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			extra_q    <= 1'b0;
			ovalid_q   <= 1'b0;
			held_cnt_q <= '0;
			pdir_q     <= '0;
			ndir_q     <= '0;
			rising_q   <= 1'b0;
			nrising_q  <= 1'b0;
			hold_q     <= 1'b0;
			idx_q      <= '0;
			ev_q       <= '0;
			mcnt_q     <= '0;
			for (int i = 0; i < NF; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				extra_q <= cfg_wdata;
			end
			if (state_q == ST_EMIT && (!ovalid_q || features.ready)) begin
				ovalid_q <= 1'b1;
			end else if (features.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					hold_q <= idx_q == 2'd1;
					ndir_q <= dir;
					if (idx_q == 2'd1) begin
						nrising_q <= rise;
						ev_q      <= {yc, xc, 4'b0000};
					end else if (idx_q == 2'd2) begin
						ev_q <= {yc, xc, extra_q && rising_q && fall, turn,
						         held_cnt_q == 2'd2, held_cnt_q != 2'd0};
						if (extra_q && rising_q && fall) begin
							nrising_q <= 1'b0;
						end else if (extra_q && !rising_q && rise) begin
							nrising_q <= 1'b1;
						end else begin
							nrising_q <= rising_q;
						end
					end else begin
						nrising_q <= rising_q;
						ev_q      <= '0;
					end
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (ev_q[0]) begin
						ev_q[0] <= 1'b0;
						state_q <= ST_EMIT;
					end else if (ev_q[1]) begin
						ev_q[1] <= 1'b0;
						state_q <= ST_EMIT;
					end else if (ev_q[2]) begin
						ev_q[2] <= 1'b0;
						state_q <= ST_EMIT;
					end else if (ev_q[3]) begin
						ev_q[3] <= 1'b0;
						state_q <= ST_EMIT;
					end else if (ev_q[4]) begin
						ev_q[4] <= 1'b0;
						state_q <= ST_DIV;
					end else if (ev_q[5]) begin
						ev_q[5] <= 1'b0;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					mcnt_q <= '0;
					if (ddone) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 3'(NF)) begin
						if (hold_q) begin
							held_cnt_q <= held_cnt_q + 1'b1;
							state_q    <= ST_PICK;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!ovalid_q || features.ready) begin
						state_q <= ST_PICK;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					for (int i = 0; i < NF; i++) begin
						prev_q[i] <= eot_q ? '0 : cur_q[i];
					end
					if (eot_q) begin
						pdir_q     <= '0;
						rising_q   <= 1'b0;
						idx_q      <= '0;
						held_cnt_q <= '0;
					end else begin
						if (idx_q != 2'd0) begin
							pdir_q   <= ndir_q;
							rising_q <= nrising_q;
						end
						if (idx_q == 2'd2) begin
							held_cnt_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			cur_q[0] <= samples.data.pos_x;
			cur_q[1] <= samples.data.pos_y;
			cur_q[2] <= samples.data.sample_time;
			cur_q[3] <= samples.data.distance;
			cur_q[4] <= samples.data.vel_x;
			cur_q[5] <= samples.data.vel_y;
			eot_q    <= samples.data.end_of_track;
		end
		if (state_q == ST_PICK) begin
			if (ev_q[0] || ev_q[1]) begin
				for (int i = 0; i < NF; i++) begin
					pt_q[i] <= ev_q[0] ? held_pt_q[0][i] : held_pt_q[1][i];
				end
				kind_q <= ev_q[0] ? held_kind_q[0] : held_kind_q[1];
			end else if (ev_q[2] || ev_q[3]) begin
				for (int i = 0; i < NF; i++) begin
					pt_q[i] <= prev_q[i];
				end
				kind_q <= ev_q[2] ? KIND_TURN : KIND_MAX;
			end else begin
				cf_q   <= !ev_q[4];
				kind_q <= ev_q[4] ? KIND_YAX : KIND_XAX;
			end
		end
		if (state_q == ST_MUL && mcnt_q != 3'd0) begin
			pt_q[mcnt_q - 3'd1] <= mres;
		end
		if (state_q == ST_MUL && mcnt_q == 3'(NF) && hold_q) begin
			for (int i = 0; i < NF - 1; i++) begin
				held_pt_q[held_cnt_q[0]][i] <= pt_q[i];
			end
			held_pt_q[held_cnt_q[0]][NF-1] <= mres;
			held_kind_q[held_cnt_q[0]]     <= cf_q ? KIND_XAX : KIND_YAX;
		end
		if (state_q == ST_EMIT && (!ovalid_q || features.ready)) begin
			out_q.kind         <= kind_q;
			out_q.out_x        <= pt_q[0];
			out_q.out_y        <= pt_q[1];
			out_q.out_time     <= pt_q[2];
			out_q.out_distance <= pt_q[3];
			out_q.out_vel_x    <= pt_q[4];
			out_q.out_vel_y    <= pt_q[5];
			out_q.last_result  <= ev_q == 6'b000000;
		end
	end
endmodule

// ----- hw/rtl/tfd_div.sv -----
module tfd_div import tfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  div_req_t      req,
	output logic          done,
	output logic [FW-1:0] frac
);
	localparam int CW = $clog2(FB + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW+2:0] rem_q;
	logic [DW:0]   den_q;
	logic [FW-1:0] quo_q;
	logic [FW-1:0] frac_q;
	logic [DW+2:0] rem_sh;
	logic          take;
	logic [FW-1:0] quo_nx;
	logic [FW:0]   quo_rnd;

	assign rem_sh  = {rem_q[DW+1:0], 1'b0};
	assign take    = rem_sh >= {2'b00, den_q};
	assign quo_nx  = {quo_q[FW-2:0], take};
	assign quo_rnd = {1'b0, quo_nx} + {{FW{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.num >= req.den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(FB)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {2'b00, req.num};
			den_q  <= req.den;
			quo_q  <= '0;
			frac_q <= FW'(1) << FB;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {2'b00, den_q} : rem_sh;
			quo_q <= quo_nx;
			if (cnt_q == CW'(FB)) begin
				frac_q <= quo_rnd[FW:1];
			end
		end
	end

	assign done = done_q;
	assign frac = frac_q;
endmodule

// ----- hw/rtl/tfd_mul.sv -----
module tfd_mul import tfd_pkg::*; (
	input  logic                 clk,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	input  logic [FW-1:0]        frac,
	output logic signed [DW-1:0] res
);
	localparam int MW = DW + 1 + FW;

	logic signed [DW:0]   delta;
	logic [DW:0]          mag;
	logic [MW-1:0]        prod_s1;
	logic signed [DW-1:0] a_s1;
	logic                 neg_s1;
	logic [MW-1:0]        rnd;
	logic [DW:0]          step;
	logic [DW+1:0]        sum;

	assign delta = {b[DW-1], b} - {a[DW-1], a};
	assign mag   = delta[DW] ? -delta : delta;

	always_ff @(posedge clk) begin
		prod_s1 <= MW'(mag) * MW'(frac);
		a_s1    <= a;
		neg_s1  <= delta[DW];
	end

	assign rnd  = prod_s1 + (MW'(1) << (FB - 1));
	assign step = rnd[FB +: DW+1];
	assign sum  = neg_s1 ? {{2{a_s1[DW-1]}}, a_s1} - {1'b0, step}
	                     : {{2{a_s1[DW-1]}}, a_s1} + {1'b0, step};
	assign res  = sum[DW-1:0];
endmodule

// ----- test/trajectory_feature_detector_tb.sv -----
module trajectory_feature_detector_tb;
	import tfd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	tfd_sample_if  samples();
	tfd_feature_if features();

	trajectory_feature_detector uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples.sink),
		.features (features.source),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		sample_t  smp;
		bit       typed;
		feature_t want;
	} stim_row_t;

	// predictor state
	logic signed [DW-1:0] last_pt [NF];
	logic signed [DW:0]   last_dir;
	bit                   going_up;
	int                   seen;
	logic signed [DW-1:0] held_pt [2][NF];
	logic [1:0]           held_kind [2];
	int                   held_n;
	bit                   extra_on;

	feature_t   feature_q [$];
	idle_mode_t idle_mode = IDLE_NONE;
	int         stall_left = 0;
	int         errors = 0;
	int         mismatches = 0;
	int         sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#40000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [DW:0] frac_of(logic [DW:0] n, logic [DW:0] d);
		logic [DW+1:0] r;
		logic [FW:0]   q;
		if (n >= d)
			return (DW+1)'(1) << FB;
		r = n;
		q = '0;
		for (int i = 0; i < FB + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		return (DW+1)'((q + 1) >> 1);
	endfunction

	function automatic logic signed [DW-1:0] lerp(logic signed [DW-1:0] a,
			logic signed [DW-1:0] b, logic [DW:0] f);
		logic signed [63:0] dlt;
		logic [63:0]        mag, p;
		dlt = 64'(b) - 64'(a);
		mag = dlt < 0 ? -dlt : dlt;
		p = (((mag & 64'hFFFF_FFFF) * f + (64'd1 << (FB - 1))) >> FB)
			+ (((mag >> 32) * f) << (32 - FB));
		return dlt < 0 ? DW'(64'(a) - p) : DW'(64'(a) + p);
	endfunction

	function automatic bit sign_flip(logic signed [DW-1:0] p, logic signed [DW-1:0] c);
		return (p <= 0 && c > 0) || (p > 0 && c <= 0);
	endfunction

	function automatic void fields_of(sample_t s, output logic signed [DW-1:0] v [NF]);
		v[0] = s.pos_x; v[1] = s.pos_y; v[2] = s.sample_time;
		v[3] = s.distance; v[4] = s.vel_x; v[5] = s.vel_y;
	endfunction

	function automatic feature_t make_feature(logic [1:0] k, logic signed [DW-1:0] v [NF]);
		feature_t r;
		r.kind = k; r.out_x = v[0]; r.out_y = v[1]; r.out_time = v[2];
		r.out_distance = v[3]; r.out_vel_x = v[4]; r.out_vel_y = v[5];
		r.last_result = 1'b0;
		return r;
	endfunction

	function automatic void crossing_at(logic signed [DW-1:0] cur [NF], int idx,
			output logic signed [DW-1:0] pt [NF]);
		logic signed [DW:0] p, c;
		logic [DW:0]        n, d, f;
		p = last_pt[idx];
		c = cur[idx];
		if (p <= 0) begin
			n = -p;
			d = c - p;
		end else begin
			n = p;
			d = p - c;
		end
		f = frac_of(n, d);
		for (int j = 0; j < NF; j++)
			pt[j] = lerp(last_pt[j], cur[j], f);
	endfunction

	function automatic void clear_track();
		for (int j = 0; j < NF; j++)
			last_pt[j] = '0;
		last_dir = '0;
		going_up = 0;
		seen = 0;
		held_n = 0;
	endfunction

	function automatic void predict_features(sample_t s, ref feature_t outs [$]);
		logic signed [DW-1:0] cur [NF];
		logic signed [DW-1:0] pt [NF];
		logic signed [DW:0]   dir;
		outs = {};
		fields_of(s, cur);
		if (seen == 1) begin
			last_dir = (DW+1)'(cur[3]) - (DW+1)'(last_pt[3]);
			going_up = cur[1] > last_pt[1];
			if (extra_on) begin
				if (sign_flip(last_pt[0], cur[0])) begin
					crossing_at(cur, 0, held_pt[held_n]);
					held_kind[held_n++] = KIND_YAX;
				end
				if (sign_flip(last_pt[1], cur[1])) begin
					crossing_at(cur, 1, held_pt[held_n]);
					held_kind[held_n++] = KIND_XAX;
				end
			end
		end else if (seen >= 2) begin
			dir = (DW+1)'(cur[3]) - (DW+1)'(last_pt[3]);
			for (int h = 0; h < held_n; h++)
				outs = {outs, make_feature(held_kind[h], held_pt[h])};
			held_n = 0;
			if ((dir > 0 && last_dir <= 0) || (dir < 0 && last_dir >= 0))
				outs = {outs, make_feature(KIND_TURN, last_pt)};
			last_dir = dir;
			if (extra_on) begin
				if (going_up && cur[1] < last_pt[1]) begin
					going_up = 0;
					outs = {outs, make_feature(KIND_MAX, last_pt)};
				end else if (!going_up && cur[1] > last_pt[1]) begin
					going_up = 1;
				end
				if (sign_flip(last_pt[0], cur[0])) begin
					crossing_at(cur, 0, pt);
					outs = {outs, make_feature(KIND_YAX, pt)};
				end
				if (sign_flip(last_pt[1], cur[1])) begin
					crossing_at(cur, 1, pt);
					outs = {outs, make_feature(KIND_XAX, pt)};
				end
			end
		end
		for (int j = 0; j < NF; j++)
			last_pt[j] = cur[j];
		if (seen < 2)
			seen++;
		if (s.end_of_track)
			clear_track();
		if (outs.size() > 0)
			outs[outs.size() - 1].last_result = 1'b1;
	endfunction

	// receiver
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			features.ready <= 1'b0;
		end else if (idle_mode == IDLE_RECV)
			features.ready <= ($urandom_range(99) >= 81);
		else if (idle_mode == IDLE_BOTH)
			features.ready <= ($urandom_range(99) >= 25);
		else
			features.ready <= 1'b1;
	end

	always @(posedge clk) begin
		feature_t want;
		if (arst_n && features.valid && features.ready) begin
			if (feature_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected feature %p", features.data);
			end else begin
				want = feature_q.pop_front();
				if (features.data !== want) begin
					errors++;
					if (mismatches++ < 10)
						$display("feature mismatch: expected %p actual %p", want,
							features.data);
				end
			end
		end
	end

	function automatic sample_t rand_sample(bit eot);
		sample_t s;
		int mode;
		mode = $urandom_range(9);
		if (mode < 6) begin
			s.pos_x = $signed($urandom_range(40000)) - 20000;
			s.pos_y = $signed($urandom_range(40000)) - 20000;
			s.sample_time = $urandom;
			s.distance = $signed($urandom_range(2000)) - 1000;
			s.vel_x = $urandom;
			s.vel_y = $urandom;
		end else if (mode < 8) begin
			s.pos_x = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			s.pos_y = $urandom_range(1) ? $urandom : 32'sd0;
			s.sample_time = $urandom;
			s.distance = $urandom;
			s.vel_x = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			s.vel_y = $urandom;
		end else begin
			s.pos_x = $urandom;
			s.pos_y = $urandom;
			s.sample_time = $urandom;
			s.distance = $urandom;
			s.vel_x = $urandom;
			s.vel_y = $urandom;
		end
		s.end_of_track = eot;
		return s;
	endfunction

	task automatic send_sample(sample_t s);
		feature_t outs [$];
		int       idle_pct;
		idle_pct = (idle_mode == IDLE_SEND) ? 81 : ((idle_mode == IDLE_BOTH) ? 25 : 0);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		samples.data <= s;
		samples.valid <= 1'b1;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		predict_features(s, outs);
		foreach (outs[i])
			feature_q = {feature_q, outs[i]};
		sent++;
		@(negedge clk);
		samples.valid <= 1'b0;
	endtask

	task automatic drain();
		while (feature_q.size() > 0)
			@(negedge clk);
		repeat (200)
			@(negedge clk);
	endtask

	task automatic write_extra(bit v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		extra_on = v;
	endtask

	function automatic sample_t mk(int x, int y, int t, int d, int vx, int vy, bit e);
		sample_t s;
		s.pos_x = x; s.pos_y = y; s.sample_time = t; s.distance = d;
		s.vel_x = vx; s.vel_y = vy; s.end_of_track = e;
		return s;
	endfunction

	task automatic random_track(int len);
		for (int i = 0; i < len; i++)
			send_sample(rand_sample(i == len - 1 || $urandom_range(49) == 0));
	endtask

	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		sample_t   s;
		int        len;
		samples.valid = 1'b0;
		samples.data = '0;
		features.ready = 1'b0;
		extra_on = 0;
		clear_track();
		repeat (9)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// turn at sample two with extra off: typed
		r.typed = 0;
		r.smp = mk(100, 5, 0, 10, 1, 2, 0); rows = {rows, r};
		r.smp = mk(200, 6, 1, 20, 3, 4, 0); rows = {rows, r};
		r.smp = mk(300, 7, 2, 15, 5, 6, 1);
		r.typed = 1;
		r.want = make_feature(KIND_TURN, '{200, 6, 1, 20, 3, 4});
		r.want.last_result = 1'b1;
		rows = {rows, r};
		r.typed = 0;
		r.smp = mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 0); rows = {rows, r};
		r.smp = mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0); rows = {rows, r};
		r.smp = mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 1); rows = {rows, r};
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				s = rows[i].smp;
				send_sample(s);
				if (feature_q.size() == 0 || feature_q[$] !== rows[i].want) begin
					errors++;
					$display("directed row %0d: predictor disagrees with table", i);
				end
			end else
				send_sample(rows[i].smp);
		end
		rows = {};

		write_extra(1);
		// held crossings, maximum, crossings at zero and at extremes
		r.typed = 0;
		r.smp = mk(-100, -50, 0, 5, 10, -10, 0); rows = {rows, r};
		r.smp = mk(100, 50, 65536, 10, 20, 10, 0); rows = {rows, r};
		r.smp = mk(0, 20, 131072, 5, 30, 0, 0); rows = {rows, r};
		r.smp = mk(5, 0, 196608, 5, 40, -5, 0); rows = {rows, r};
		r.smp = mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 0); rows = {rows, r};
		r.smp = mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 1); rows = {rows, r};
		// track ends before the held crossings come out
		r.smp = mk(-1, -1, 0, 0, 0, 0, 0); rows = {rows, r};
		r.smp = mk(1, 1, 1, 1, 1, 1, 1); rows = {rows, r};
		r.smp = mk(-1, 1, 0, 0, 0, 0, 0); rows = {rows, r};
		r.smp = mk(1, -1, 1, 1, 1, 1, 0); rows = {rows, r};
		foreach (rows[i])
			send_sample(rows[i].smp);
		// held crossings still come out with extra cleared
		write_extra(0);
		send_sample(mk(2, 3, 2, 0, 2, 2, 1));
		write_extra(1);

		for (int ph = 0; ph < 4; ph++) begin
			idle_mode = idle_mode_t'(ph);
			if (ph == 2)
				write_extra(0);
			if (ph == 3)
				write_extra(1);
			while (sent < 40 + 105 * (ph + 1)) begin
				len = $urandom_range(10) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 25);
				random_track(len);
			end
			if (ph == 1) begin
				idle_mode = IDLE_NONE;
				stall_left = 400;
				random_track(20);
				drain();
			end
		end
		idle_mode = IDLE_NONE;
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_sample_if.sv
hw/rtl/tfd_feature_if.sv
hw/rtl/tfd_div.sv
hw/rtl/tfd_mul.sv
hw/rtl/trajectory_feature_detector.sv
test/trajectory_feature_detector_tb.sv
